[hdl/wds_pkg.sv]
// ----------------------------------------------------------------------------
// wds_pkg: shared types and constants of the delay statistics block
// Window size, derived widths, the queue entry and the back-end state type.
// ----------------------------------------------------------------------------
package wds_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int DELAY_W      = 32;
  localparam int SAMPLE_W     = 16;
  localparam int FILL_W       = 5;
  localparam int OUT_DATA_W   = 88;

  localparam logic [DELAY_W-1:0]  MIN_RESET = '1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // Request kinds carried on the input tuser bit.
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_t;

  // One classified request waiting for the back end.
  typedef struct packed {
    req_t                kind;
    logic [DELAY_W-1:0]  delay;
    logic [SAMPLE_W-1:0] sat;
  } item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_EMIT
  } back_state_t;

endpackage

[hdl/wds_front.sv]
// ----------------------------------------------------------------------------
// wds_front: request intake
// Accepts requests while the queue has room, decodes the kind and
// saturates the sample to the window width.
// ----------------------------------------------------------------------------
module wds_front import wds_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [DELAY_W-1:0]  in_tdata,
  input  logic                in_tuser,
  input  qstat_t              q_stat,
  output logic                q_push,
  output item_t               q_item
);

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_item.kind  = req_t'(in_tuser);
    q_item.delay = in_tdata;
    if (in_tdata > DELAY_W'(SAMPLE_MAX)) begin
      q_item.sat = SAMPLE_MAX;
    end else begin
      q_item.sat = in_tdata[SAMPLE_W-1:0];
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_push)
    else $error("request taken while the queue is full");

  a_ready_tracks_room: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.full |-> in_tready)
    else $error("intake stalled with room in the queue");

  a_push_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> in_tvalid && !q_stat.full)
    else $error("push without a valid request");

endmodule

[hdl/wds_queue.sv]
// ----------------------------------------------------------------------------
// wds_queue: two-entry request queue
// Decouples intake from the statistics engine.
// ----------------------------------------------------------------------------
module wds_queue import wds_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  head,
  output qstat_t stat
);

  item_t       mem_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop  ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  assign head       = mem_r[rptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from an empty queue");

  a_ptrs_match: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with an empty count");

endmodule

[hdl/wds_back.sv]
// ----------------------------------------------------------------------------
// wds_back: statistics engine
// Applies one request to min, max and the sample window, then, for a
// sample, ranks one window entry per cycle to find the upper median.
// ----------------------------------------------------------------------------
module wds_back import wds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  item_t                 head,
  input  qstat_t                q_stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  back_state_t          state_r, state_nxt;
  logic [SAMPLE_W-1:0]  ring_r [WINDOW_DEPTH];
  logic [IDX_W-1:0]     wpos_r;
  logic [CNT_W-1:0]     fill_r;
  logic [DELAY_W-1:0]   min_r;
  logic [DELAY_W-1:0]   max_r;
  logic [IDX_W-1:0]     cand_r;
  logic [SAMPLE_W-1:0]  med_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                 out_free;
  logic                 rank_hit;
  logic                 load_out;
  logic                 found;
  logic [SAMPLE_W-1:0]  cand_val;
  logic [CNT_W-1:0]     n_less;
  logic [CNT_W-1:0]     n_leq;
  logic [CNT_W-1:0]     half;

  assign out_free = !out_valid_r || out_tready;

  // Rank the candidate against every valid entry in parallel.
  always_comb begin
    cand_val = ring_r[cand_r];
    n_less   = '0;
    n_leq    = '0;
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      if (CNT_W'(j) < fill_r) begin
        n_less = n_less + CNT_W'(ring_r[j] <  cand_val);
        n_leq  = n_leq  + CNT_W'(ring_r[j] <= cand_val);
      end
    end
    half  = fill_r >> 1;
    found = (n_less <= half) && (n_leq > half);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (head.kind == REQ_CLEAR) ? ST_EMIT : ST_RANK;
        end
      end
      ST_RANK: begin
        if (found) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    rank_hit = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: pop      = !q_stat.empty;
      ST_RANK: rank_hit = found;
      ST_EMIT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wpos_r      <= '0;
      fill_r      <= '0;
      min_r       <= MIN_RESET;
      max_r       <= '0;
      cand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        cand_r <= '0;
        if (head.kind == REQ_CLEAR) begin
          wpos_r <= '0;
          fill_r <= '0;
          min_r  <= MIN_RESET;
          max_r  <= '0;
        end else begin
          if (head.delay < min_r) begin
            min_r <= head.delay;
          end
          if (head.delay > max_r) begin
            max_r <= head.delay;
          end
          wpos_r <= (wpos_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wpos_r + 1'b1;
          if (fill_r < CNT_W'(WINDOW_DEPTH)) begin
            fill_r <= fill_r + 1'b1;
          end
        end
      end else if (state_r == ST_RANK && !rank_hit) begin
        cand_r <= cand_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Window contents, median and result payload.
  always_ff @(posedge clk) begin
    if (pop && head.kind == REQ_SAMPLE) begin
      ring_r[wpos_r] <= head.sat;
    end
    if (pop) begin
      med_r <= '0;
    end else if (rank_hit) begin
      med_r <= cand_val;
    end
    if (load_out) begin
      out_data_r <= {3'b000, FILL_W'(fill_r), med_r, max_r, min_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_DEPTH))
    else $error("window fill exceeds the window size");

  a_rank_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RANK) |-> (CNT_W'(cand_r) < fill_r))
    else $error("median search ran past the valid entries");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == REQ_CLEAR) |=> (fill_r == '0) && (max_r == '0))
    else $error("clear did not empty the statistics");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> !$changed(out_data_r) || !out_valid_r)
    else $error("pending result overwritten");

endmodule

[hdl/window_delay_statistics.sv]
// ----------------------------------------------------------------------------
// window_delay_statistics: running min/max and sliding-window median
// Tracks delay samples and answers every request with the statistics.
// ----------------------------------------------------------------------------
// Each request on the input stream is either a delay sample (tuser = 0) or a
// clear (tuser = 1), and each one produces exactly one result transfer that
// reflects the state after the request: the running minimum and maximum of
// the exact 32-bit samples since the last clear, the number of samples held
// in the 16-entry window, and the upper median (sorted element fill/2) of the
// window, where samples enter saturated to 16 bits. A clear restores the
// minimum to all ones and the maximum to zero, and empties the window, so its
// result carries a median and fill of zero. Results come out in request
// order. The engine pops a request in its idle state; for a sample, the
// median search then ranks window entries in order, comparing one candidate
// entry against the whole window each cycle, until it finds the median; a
// clear skips the search. The emit state then loads the result register. A
// two-entry queue after the input lets up to two requests be taken while the
// engine is busy, and the result register lets the engine pop and rank the
// next request while a result still waits on out_tready.
// ----------------------------------------------------------------------------
module window_delay_statistics import wds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DELAY_W-1:0]    in_tdata,   // [31:0] delay_value
  input  logic                  in_tuser,   // [0] req_type
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [31:0] min_delay, [63:32] max_delay,
                                            // [79:64] median_delay,
                                            // [84:80] window_fill, rest zero
);

  item_t  push_item;
  item_t  head;
  qstat_t q_stat;
  logic   push;
  logic   pop;

  // Intake: decodes and saturates each request as it is accepted.
  wds_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (push),
    .q_item    (push_item)
  );

  // Short queue so intake and the engine stall independently.
  wds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Engine: state update, median search and the result register.
  wds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the delay statistics block
// Sends sample and clear requests with random gaps and output stalls, and
// checks every result transfer against a local statistics predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import wds_pkg::*;

  localparam int  RANDOM_REQUESTS = 1050;
  localparam int  DRAIN_CYCLES    = 120;
  localparam real TIMEOUT_NS      = 5_000_000.0;

  // One request as it travels on the input stream.
  typedef struct {
    req_t               kind;
    logic [DELAY_W-1:0] delay;
  } delay_req_t;

  // The statistics carried by one result transfer.
  typedef struct {
    logic [DELAY_W-1:0]  min_delay;
    logic [DELAY_W-1:0]  max_delay;
    logic [SAMPLE_W-1:0] median_delay;
    logic [FILL_W-1:0]   window_fill;
  } stats_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DELAY_W-1:0]    in_tdata = '0;
  logic                  in_tuser = REQ_SAMPLE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  delay_req_t request_q[$];
  stats_t     expected_stats_q[$];
  int         mismatch_count = 0;

  // Predictor state: exact running extremes and the saturated sample window.
  logic [DELAY_W-1:0]  run_min = MIN_RESET;
  logic [DELAY_W-1:0]  run_max = '0;
  logic [SAMPLE_W-1:0] window_ring[WINDOW_DEPTH];
  int                  ring_wr = 0;
  int                  ring_fill = 0;

  // Driver and monitor bookkeeping.
  delay_req_t cur_req;
  int         drv_gap = 0;
  int         drv_phase_left = 0;
  bit         drv_quiet = 1'b0;
  int         mon_stall = 0;
  int         mon_phase_left = 0;
  bit         mon_quiet = 1'b0;
  stats_t     want;

  window_delay_statistics dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Upper median of the valid window entries: sort positions 0 .. fill-1 and
  // take element fill/2. An empty window reads as zero.
  function automatic logic [SAMPLE_W-1:0] window_median();
    logic [SAMPLE_W-1:0] sorted[WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] v;
    int                  j;
    if (ring_fill == 0) return '0;
    for (int i = 0; i < ring_fill; i++) begin
      v = window_ring[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[ring_fill/2];
  endfunction

  // Applies one accepted request to the predictor and queues the statistics
  // that the block must return for it.
  task automatic apply_request(req_t kind, logic [DELAY_W-1:0] delay);
    stats_t s;
    if (kind == REQ_CLEAR) begin
      // The ring contents stay put but are no longer counted.
      run_min   = MIN_RESET;
      run_max   = '0;
      ring_wr   = 0;
      ring_fill = 0;
    end else begin
      if (delay < run_min) run_min = delay;
      if (delay > run_max) run_max = delay;
      // Samples above the 16-bit range enter the window saturated.
      window_ring[ring_wr] = (delay > DELAY_W'(SAMPLE_MAX)) ? SAMPLE_MAX : delay[SAMPLE_W-1:0];
      ring_wr = (ring_wr + 1 >= WINDOW_DEPTH) ? 0 : ring_wr + 1;
      if (ring_fill < WINDOW_DEPTH) ring_fill++;
    end
    s.min_delay    = run_min;
    s.max_delay    = run_max;
    s.median_delay = window_median();
    s.window_fill  = FILL_W'(ring_fill);
    expected_stats_q.push_back(s);
  endtask

  task automatic push_request(req_t kind, logic [DELAY_W-1:0] delay);
    delay_req_t r;
    r.kind  = kind;
    r.delay = delay;
    request_q.push_back(r);
  endtask

  // Gap or stall length: mostly none, often short, now and then long.
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 93) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  task automatic compare_field(string name, logic [DELAY_W-1:0] exp_v,
                               logic [DELAY_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Driver: presents queued requests on the input stream. A request counts as
  // taken at the edge where valid and ready are both high; that is where the
  // predictor runs, so expectations follow the order of acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= REQ_SAMPLE;
    end else begin
      // At the end of each phase decide whether the next stretch runs flat out.
      if (drv_phase_left == 0) begin
        drv_quiet      = ($urandom_range(0, 3) == 0);
        drv_phase_left = $urandom_range(50, 300);
      end else begin
        drv_phase_left--;
      end
      if (in_tvalid && in_tready) begin
        apply_request(req_t'(in_tuser), in_tdata);
        drv_gap = pick_gap(drv_quiet);
      end
      if (!in_tvalid || in_tready) begin
        if (drv_gap > 0) begin
          in_tvalid <= 1'b0;
          drv_gap--;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cur_req.delay;
          in_tuser  <= cur_req.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result stream at random and checks each transfer
  // against the oldest expected statistics.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (mon_phase_left == 0) begin
        mon_quiet      = ($urandom_range(0, 3) == 0);
        mon_phase_left = $urandom_range(50, 300);
      end else begin
        mon_phase_left--;
      end
      if (out_tvalid && out_tready) begin
        if (expected_stats_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_stats_q.pop_front();
          compare_field("min_delay", want.min_delay, out_tdata[31:0]);
          compare_field("max_delay", want.max_delay, out_tdata[63:32]);
          compare_field("median_delay", DELAY_W'(want.median_delay),
                        DELAY_W'(out_tdata[79:64]));
          compare_field("window_fill", DELAY_W'(want.window_fill),
                        DELAY_W'(out_tdata[84:80]));
          compare_field("tdata padding", '0, DELAY_W'(out_tdata[OUT_DATA_W-1:85]));
        end
      end
      if (mon_stall > 0) begin
        out_tready <= 1'b0;
        mon_stall--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) mon_stall = pick_gap(mon_quiet);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [DELAY_W-1:0] val;
    int                 pick;

    // Directed part: field extremes, saturation at the 16-bit boundary, a
    // clear of a busy window and of an empty one, then enough samples to wrap
    // the window with odd and even fill counts along the way.
    push_request(REQ_SAMPLE, 32'h0000_0000);
    push_request(REQ_SAMPLE, 32'hFFFF_FFFF);
    push_request(REQ_SAMPLE, 32'h0000_FFFF);
    push_request(REQ_SAMPLE, 32'h0001_0000);
    push_request(REQ_SAMPLE, 32'h0000_0001);
    push_request(REQ_CLEAR,  32'hFFFF_FFFF);
    push_request(REQ_CLEAR,  32'h0000_0000);
    for (int i = 0; i < 18; i++) begin
      val = (i % 5 == 0) ? 32'h0001_0000 + i : 32'd1000 - i * 37;
      push_request(REQ_SAMPLE, val);
    end
    push_request(REQ_CLEAR, 32'hA5A5_5A5A);

    // Random part: mostly runs of samples between occasional clears, so the
    // window keeps filling, wrapping and emptying. Clears carry random data,
    // which the block must ignore.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 29) == 0) begin
        push_request(REQ_CLEAR, $urandom());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) val = $urandom_range(0, 1000);
        else if (pick < 60) val = $urandom_range(0, 65535);
        else if (pick < 70) val = $urandom_range(65529, 65542);
        else if (pick < 90) val = $urandom();
        else begin
          case ($urandom_range(0, 3))
            0: val = 32'h0000_0000;
            1: val = 32'hFFFF_FFFF;
            2: val = 32'h0000_FFFF;
            default: val = 32'h0001_0000;
          endcase
        end
        push_request(REQ_SAMPLE, val);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Checked between edges, once the driver's and monitor's updates have
    // settled: nothing left to send, nothing on the bus and nothing owed.
    while (request_q.size() > 0 || in_tvalid || expected_stats_q.size() > 0) begin
      @(negedge clk);
    end
    // Any stray extra result would show up within the block's latency plus
    // the longest output stall.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
